@@ rtl/core/utf8_stream_decoder_top_defines.svh @@
// Assertion macros used by the decoder top.
`ifndef UTF8_STREAM_DECODER_TOP_DEFINES_SVH
`define UTF8_STREAM_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Checked on every rising edge of clk_i, held off while rst_ni is low.
`define UTF8D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Checked on every rising edge of clk_i, reset included.
`define UTF8D_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define UTF8D_ASSERT(lbl, prop, msg)
`define UTF8D_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/core/utf8d_pkg.sv @@
package utf8d_pkg;

  localparam logic [20:0] ReplacementChar = 21'h00FFFD;

  localparam logic [7:0] ContMin     = 8'h80;
  localparam logic [7:0] ContMax     = 8'hBF;
  localparam logic [7:0] LeadE0Min   = 8'hA0;
  localparam logic [7:0] LeadEDMax   = 8'h9F;
  localparam logic [7:0] LeadF0Min   = 8'h90;
  localparam logic [7:0] LeadF4Max   = 8'h8F;
  localparam logic [7:0] LeadE0      = 8'hE0;
  localparam logic [7:0] LeadED      = 8'hED;
  localparam logic [7:0] LeadF0      = 8'hF0;
  localparam logic [7:0] LeadF4      = 8'hF4;
  localparam logic [7:0] LeadMin     = 8'hC2;
  localparam logic [7:0] Lead3Min    = 8'hE0;
  localparam logic [7:0] Lead4Min    = 8'hF0;

  // Decoder state between bytes.
  typedef struct packed {
    logic [7:0]  lead;
    logic [1:0]  count;
    logic [14:0] partial;
  } state_t;

  // Results caused by one byte: pre errors, an optional main result at
  // position pre, then trailing flush errors.
  typedef struct packed {
    logic [2:0]  n;
    logic        main_valid;
    logic [1:0]  main_pos;
    logic [20:0] main_cp;
    logic        main_err;
    logic [2:0]  main_cnt;
    logic        eos;
  } burst_t;

endpackage

@@ rtl/core/utf8_stream_decoder_top.sv @@
// Channel | Dir | Handshake               | Payload
// input   | in  | in_valid_i / in_stall_o | data_byte_i, end_of_stream_i
// result  | out | out_valid_o/out_stall_i | code_point_o, is_error_o, byte_count_o,
//         |     |                         | stream_done_o, run_last_o
//
// One byte per cycle while each byte causes at most one result and the output
// is not stalled; a byte that causes several results holds the input while the
// single result register drains the burst, one result per cycle unless stalled.
// A byte is registered in the burst register, then its results in the result register.
// Reset clears the held sequence, the burst counter and the output valid.
// A stalled output holds the result register and, once the burst is down
// to its last result, the input as well.
`include "utf8_stream_decoder_top_defines.svh"

module utf8_stream_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_stream_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [20:0] code_point_o,
  output logic        is_error_o,
  output logic [2:0]  byte_count_o,
  output logic        stream_done_o,
  output logic        run_last_o
);
  import utf8d_pkg::*;

  state_t      state_q, state_d;
  burst_t      burst_new;
  burst_t      burst_q;
  logic [2:0]  rem_q, rem_d;
  logic [1:0]  pos_q, pos_d;
  logic        out_valid_q, out_valid_d;
  logic        accept, out_load, sel_main;
  logic [20:0] cp_q;
  logic        err_q, done_q, last_q;
  logic [2:0]  cnt_q;

  utf8d_decode u_decode (
    .state_i         (state_q),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .state_o         (state_d),
    .burst_o         (burst_new)
  );

  assign out_load   = (rem_q != 3'd0) && (!out_valid_q || !out_stall_i);
  assign in_stall_o = !((rem_q == 3'd0) || ((rem_q == 3'd1) && out_load));
  assign accept     = in_valid_i && !in_stall_o;
  assign sel_main   = burst_q.main_valid && (pos_q == burst_q.main_pos);

  always_comb begin
    rem_d = rem_q;
    pos_d = pos_q;
    if (accept) begin
      rem_d = burst_new.n;
      pos_d = 2'd0;
    end else if (out_load) begin
      rem_d = rem_q - 3'd1;
      pos_d = pos_q + 2'd1;
    end
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= '0;
      rem_q       <= 3'd0;
      pos_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      rem_q       <= rem_d;
      pos_q       <= pos_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      burst_q <= burst_new;
    end
    if (out_load) begin
      cp_q   <= sel_main ? burst_q.main_cp  : ReplacementChar;
      err_q  <= sel_main ? burst_q.main_err : 1'b1;
      cnt_q  <= sel_main ? burst_q.main_cnt : 3'd1;
      last_q <= (rem_q == 3'd1);
      done_q <= (rem_q == 3'd1) && burst_q.eos;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_point_o  = cp_q;
  assign is_error_o    = err_q;
  assign byte_count_o  = cnt_q;
  assign stream_done_o = done_q;
  assign run_last_o    = last_q;

  `UTF8D_ASSERT(a_accept_loads_burst, accept |=> (rem_q == $past(burst_new.n)), "burst count not loaded on accept")
  `UTF8D_ASSERT(a_burst_holds, ((rem_q != 3'd0) && !out_load && !accept) |=> $stable(rem_q), "burst advanced while output stalled")
  `UTF8D_ASSERT(a_accept_when_drained, accept |-> ((rem_q == 3'd0) || ((rem_q == 3'd1) && out_load)), "input taken with results still pending")
  `UTF8D_ASSERT(a_eos_clears_held, (accept && end_of_stream_i) |=> (state_q.count == 2'd0), "bytes still held after end of stream")
  `UTF8D_ASSERT_ALWAYS(a_burst_bound, rem_q <= 3'd4, "burst longer than four results")

endmodule

@@ rtl/core/utf8d_decode.sv @@
module utf8d_decode (
  input  utf8d_pkg::state_t state_i,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_stream_i,
  output utf8d_pkg::state_t state_o,
  output utf8d_pkg::burst_t burst_o
);
  import utf8d_pkg::*;

  logic [7:0]  lo, hi;
  logic        in_range, consumed, complete, is_lead;
  logic [20:0] value;
  logic [2:0]  need;
  logic [2:0]  pre;
  logic        main_valid;
  state_t      st;

  always_comb begin
    lo = ContMin;
    hi = ContMax;
    if (state_i.count == 2'd1) begin
      case (state_i.lead)
        LeadE0:  lo = LeadE0Min;
        LeadED:  hi = LeadEDMax;
        LeadF0:  lo = LeadF0Min;
        LeadF4:  hi = LeadF4Max;
        default: ;
      endcase
    end
    in_range = (data_byte_i >= lo) && (data_byte_i <= hi);
    consumed = (state_i.count != 2'd0) && in_range;
    value    = {state_i.partial, data_byte_i[5:0]};
    if (state_i.lead < Lead3Min) begin
      need = 3'd2;
    end else if (state_i.lead < Lead4Min) begin
      need = 3'd3;
    end else begin
      need = 3'd4;
    end
    complete = consumed && (({1'b0, state_i.count} + 3'd1) >= need);
    pre      = ((state_i.count != 2'd0) && !in_range) ? {1'b0, state_i.count} : 3'd0;
    is_lead  = data_byte_i inside {[LeadMin:LeadF4]};
  end

  always_comb begin
    st         = state_i;
    main_valid = 1'b0;
    burst_o    = '0;
    if (consumed) begin
      if (complete) begin
        st.count    = 2'd0;
        st.partial  = '0;
        main_valid  = 1'b1;
        burst_o.main_cp  = value;
        burst_o.main_err = 1'b0;
        burst_o.main_cnt = need;
      end else begin
        st.count   = state_i.count + 2'd1;
        st.partial = value[14:0];
      end
    end else begin
      st.count   = 2'd0;
      st.partial = '0;
      if (!data_byte_i[7]) begin
        main_valid       = 1'b1;
        burst_o.main_cp  = {13'd0, data_byte_i};
        burst_o.main_err = 1'b0;
        burst_o.main_cnt = 3'd1;
      end else if (is_lead) begin
        st.lead  = data_byte_i;
        st.count = 2'd1;
        if (data_byte_i < Lead3Min) begin
          st.partial = {10'd0, data_byte_i[4:0]};
        end else if (data_byte_i < Lead4Min) begin
          st.partial = {11'd0, data_byte_i[3:0]};
        end else begin
          st.partial = {12'd0, data_byte_i[2:0]};
        end
      end else begin
        main_valid       = 1'b1;
        burst_o.main_cp  = ReplacementChar;
        burst_o.main_err = 1'b1;
        burst_o.main_cnt = 3'd1;
      end
    end
    burst_o.main_valid = main_valid;
    burst_o.main_pos   = pre[1:0];
    burst_o.eos        = end_of_stream_i;
    burst_o.n          = pre + {2'd0, main_valid} +
                         (end_of_stream_i ? {1'b0, st.count} : 3'd0);
    // Flush whatever is still held at end of stream.
    if (end_of_stream_i) begin
      st.count   = 2'd0;
      st.partial = '0;
    end
    state_o = st;
  end

endmodule
